// ----- rtl/mspt_pkg.sv -----
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared types and constants for the multi-slot periodic timer.
// ----------------------------------------------------------------------------
package mspt_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int TICK_US_DEF = 100;

    // slots that the 3-bit slot field and the 8-bit mask can reach
    localparam int SLOT_FIELD_W = 3;
    localparam int MASK_W       = 8;

    // (count + 2) * tick stays at or below the larger of interval + tick and 2 * tick, so one bit over 32 is enough
    localparam int ACC_W = 33;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_SETUP = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]              kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [31:0]             span_us;
        logic                    handler_present;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [31:0]       elapsed_us;
        logic              ok;
    } result_t;

endpackage

// ----- rtl/multi_slot_periodic_timer_top.sv -----
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_top
// Bank of periodic timer slots driven by tick, setup, clear, stop and read beats.
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the stage register, then its result beat in the m_ output register
// throughput: one beat per cycle unless m_tready stalls; every command is one pass through the slot logic
// all slots compare and update in parallel on a tick
// reset: synchronous active-low aresetn; slots come up inactive with zero counts,
// no beats in flight
module multi_slot_periodic_timer_top #(
    parameter int SLOTS   = mspt_pkg::SLOTS_DEF,
    parameter int TICK_US = mspt_pkg::TICK_US_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[2:0], span_us[34:3], handler_present[35], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // fired_mask[7:0], elapsed_us[39:8], ok[40], zero pad
);
    import mspt_pkg::*;

    logic    st_valid_reg;
    cmd_t    st_cmd_reg;
    logic    m_valid_reg;
    result_t m_res_reg;
    result_t res;
    logic    out_free;
    logic    st_move;

    assign out_free = !m_valid_reg || m_tready;
    assign st_move  = st_valid_reg && out_free;
    assign s_tready = !st_valid_reg || st_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                st_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= st_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st_cmd_reg.kind            <= s_tuser;
            st_cmd_reg.slot            <= s_tdata[2:0];
            st_cmd_reg.span_us         <= s_tdata[34:3];
            st_cmd_reg.handler_present <= s_tdata[35];
        end
        if (st_move) begin
            m_res_reg <= res;
        end
    end

    mspt_bank #(
        .SLOTS   (SLOTS),
        .TICK_US (TICK_US)
    ) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (st_move),
        .cmd     (st_cmd_reg),
        .res     (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg.ok, m_res_reg.elapsed_us, m_res_reg.fired_mask};

endmodule

// ----- rtl/mspt_bank.sv -----
// ----------------------------------------------------------------------------
// mspt_bank
// Timer slot state and the combinational command logic that updates it on step_en.
// ----------------------------------------------------------------------------
module mspt_bank #(
    parameter int SLOTS   = mspt_pkg::SLOTS_DEF,
    parameter int TICK_US = mspt_pkg::TICK_US_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  mspt_pkg::cmd_t   cmd,
    output mspt_pkg::result_t res
);
    import mspt_pkg::*;

    localparam int RD_N = (SLOTS < MASK_W) ? SLOTS : MASK_W;
    localparam logic [ACC_W-1:0] TICK_ACC  = ACC_W'(TICK_US);
    localparam logic [ACC_W-1:0] TICK2_ACC = ACC_W'(2 * TICK_US);
    localparam logic [31:0]      TICK_32   = 32'(TICK_US);

    // acc_reg tracks (count + 2) * tick while a slot runs; the slot fires on a tick
    // when that value exceeds the interval, which matches count+1 >= interval/tick
    logic [31:0]      count_reg  [SLOTS];
    logic [31:0]      count_next [SLOTS];
    logic [ACC_W-1:0] acc_reg    [SLOTS];
    logic [ACC_W-1:0] acc_next   [SLOTS];
    logic [31:0]      ival_reg   [SLOTS];
    logic [31:0]      ival_next  [SLOTS];
    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] handler_reg, handler_next;

    logic             slot_ok;
    logic [31:0]      rd_count;
    logic             hit;

    always_comb begin
        slot_ok      = (32'(cmd.slot) < 32'(SLOTS));
        rd_count     = '0;
        res          = '0;
        hit          = 1'b0;
        active_next  = active_reg;
        handler_next = handler_reg;
        for (int i = 0; i < SLOTS; i++) begin
            count_next[i] = count_reg[i];
            acc_next[i]   = acc_reg[i];
            ival_next[i]  = ival_reg[i];
        end
        for (int i = 0; i < RD_N; i++) begin
            if (32'(cmd.slot) == i) begin
                rd_count = count_reg[i];
            end
        end

        case (cmd.kind)
            KIND_TICK: begin
                res.ok = 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    hit = active_reg[i] && (acc_reg[i] > {1'b0, ival_reg[i]});
                    if (hit) begin
                        count_next[i] = '0;
                        acc_next[i]   = TICK2_ACC;
                        if (i < MASK_W) begin
                            res.fired_mask[i % MASK_W] = handler_reg[i];
                        end
                    end else begin
                        count_next[i] = count_reg[i] + 32'd1;
                        if (active_reg[i]) begin
                            acc_next[i] = acc_reg[i] + TICK_ACC;
                        end
                    end
                end
            end
            KIND_CLEAR: begin
                res.ok = slot_ok;
                for (int i = 0; i < RD_N; i++) begin
                    if (slot_ok && 32'(cmd.slot) == i) begin
                        active_next[i]  = 1'b0;
                        handler_next[i] = 1'b0;
                        count_next[i]   = '0;
                    end
                end
            end
            KIND_SETUP: begin
                res.ok = slot_ok && (cmd.span_us != 32'd0);
                for (int i = 0; i < RD_N; i++) begin
                    if (res.ok && 32'(cmd.slot) == i) begin
                        ival_next[i]    = cmd.span_us;
                        acc_next[i]     = TICK2_ACC;
                        count_next[i]   = '0;
                        handler_next[i] = cmd.handler_present;
                        active_next[i]  = 1'b1;
                    end
                end
            end
            KIND_STOP: begin
                res.ok = slot_ok;
                for (int i = 0; i < RD_N; i++) begin
                    if (slot_ok && 32'(cmd.slot) == i) begin
                        active_next[i] = 1'b0;
                    end
                end
            end
            KIND_READ: begin
                res.ok = slot_ok;
                if (slot_ok) begin
                    res.elapsed_us = rd_count * TICK_32;
                end
            end
            default: begin
                res.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            handler_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (step_en) begin
            active_reg  <= active_next;
            handler_reg <= handler_next;
            for (int i = 0; i < SLOTS; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // only read while the slot runs, so no reset needed
    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int i = 0; i < SLOTS; i++) begin
                acc_reg[i]  <= acc_next[i];
                ival_reg[i] <= ival_next[i];
            end
        end
    end

endmodule
